/* rtl/assert_macros.svh */
// Assertion macros used by segment_proximity_target_detector.sv.
// Depends on nothing; each macro assumes a clock named clock, and ASSERT_CLK a reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, including during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/sptd_pkg.sv */
// Package for the segment proximity target detector: sizes, codes and datapath widths.
// Used by segment_proximity_target_detector.sv; depends on nothing.
package sptd_pkg;

   localparam int MAX_TARGETS = 64;
   localparam int IDX_W       = $clog2(MAX_TARGETS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int COORD_W     = 16;
   localparam int POS_W       = 3 * COORD_W;
   localparam int RADIUS_W    = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 1;

   // Datapath widths
   localparam int DIFF_W  = COORD_W + 1;          // coordinate difference
   localparam int PROD_W  = 2 * DIFF_W;           // product of two differences
   localparam int DOT_W   = PROD_W + 1;           // signed dot product
   localparam int SSQ_W   = PROD_W;               // sum of three squares
   localparam int CROSS_W = PROD_W + 1;           // cross product component
   localparam int LO_W    = DIFF_W;               // low part of a split operand
   localparam int HI_W    = CROSS_W - LO_W;       // high part, signed
   localparam int PP_W    = 2 * (HI_W > LO_W + 1 ? HI_W : LO_W + 1);
   localparam int NSQ_W   = 2 * CROSS_W - 2;      // sum of three cross squares
   localparam int R2_W    = 2 * RADIUS_W;
   localparam int C2LO_W  = SSQ_W / 2;
   localparam int C2HI_W  = SSQ_W - C2LO_W;
   localparam int R2C2_W  = R2_W + SSQ_W;

   localparam int REQ_DATA_W = ((IDX_W + 6 * COORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((IDX_W + 1 + 7) / 8) * 8;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TEST = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS = 1'b0,
      CSR_COUNT  = 1'b1
   } csr_type;

endpackage

/* rtl/segment_proximity_target_detector.sv */
// Segment proximity target detector: target table, per-segment setup and target pipeline.
// Depends on sptd_pkg and assert_macros.svh.
//
// A load request writes one slot of the position memory. A test request passes through the
// setup states SQ, SUM, RMUL and RSUM for the segment (squared length and squared radius times
// squared length), then reads one target a cycle from the position memory, while the result
// side does not stall, into a 7-stage distance pipeline, and ends in the drain state. The
// single read port of the position memory sets the one-target-a-cycle pace.
// Results come out in ascending target order; the last one of a segment carries tlast, and a
// segment with no target in range (or of zero length) gives one result with tuser low.
`include "assert_macros.svh"

module segment_proximity_target_detector (
   input  logic                              clock,
   input  logic                              reset,
   // request: tuser = cmd; tdata = target_index, point_a_x, point_a_y, point_a_z,
   //          point_b_x, point_b_y, point_b_z, zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sptd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   // result: tuser = hit; tdata = hit_index, first_detection, zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sptd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [sptd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sptd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sptd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_SUM,
      ST_RMUL,
      ST_RSUM,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // request fields
   logic [IDX_W-1:0]          req_idx;
   logic signed [COORD_W-1:0] req_a [3];
   logic signed [COORD_W-1:0] req_b [3];
   logic                      req_go;
   logic                      req_load;
   logic                      req_test;

   // control
   state_type                 state_ff, state_in;
   logic [RADIUS_W-1:0]       radius_ff, radius_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [CNT_W-1:0]          issue_ff, issue_in;
   logic [7:1]                vld_ff;
   logic                      issue_go;
   logic                      adv;
   logic [MAX_TARGETS-1:0]    marks_ff, marks_in;
   logic                      pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]          pend_idx_ff, pend_idx_in;
   logic                      pend_first_ff, pend_first_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0]          rsp_idx_ff, rsp_idx_in;
   logic                      rsp_first_ff, rsp_first_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      hit7;
   logic                      first7;

   // segment setup
   logic signed [COORD_W-1:0] a_ff [3];
   logic signed [COORD_W-1:0] b_ff [3];
   logic signed [DIFF_W-1:0]  v_ff [3];
   logic signed [PROD_W-1:0]  vsq_ff [3];
   logic [R2_W-1:0]           r2_ff;
   logic [SSQ_W-1:0]          c2_ff;
   logic [R2_W+C2LO_W-1:0]    rlo_ff;
   logic [R2_W+C2HI_W-1:0]    rhi_ff;
   logic [R2C2_W-1:0]         r2c2_ff;

   // position memory
   logic [POS_W-1:0]          pos_mem [MAX_TARGETS];
   logic [POS_W-1:0]          rd_ff;

   // target pipeline
   logic [IDX_W-1:0]          idx_ff [1:7];
   logic signed [DIFF_W-1:0]  wa_ff [3];
   logic signed [DIFF_W-1:0]  wb_ff [3];
   logic signed [PROD_W-1:0]  pav_ff [3];
   logic signed [PROD_W-1:0]  paa_ff [3];
   logic signed [PROD_W-1:0]  pbb_ff [3];
   logic signed [PROD_W-1:0]  pm_ff [6];
   logic signed [DOT_W-1:0]   c1_ff;
   logic [SSQ_W-1:0]          da_ff;
   logic [SSQ_W-1:0]          db_ff;
   logic signed [CROSS_W-1:0] cr_ff [3];
   logic signed [PP_W-1:0]    phh_ff [3];
   logic signed [PP_W-1:0]    phl_ff [3];
   logic [2*LO_W-1:0]         pll_ff [3];
   logic [NSQ_W-1:0]          sq_ff [3];
   logic [NSQ_W-1:0]          nsq_ff;
   logic [3:0]                flg5_ff, flg6_ff, flg7_ff;   // le0, c2le, hitA, hitB
   logic signed [HI_W-1:0]    cr_hi [3];
   logic signed [LO_W:0]      cr_lo [3];

   assign req_idx  = req_tdata[IDX_W-1:0];
   for (genvar k = 0; k < 3; k++) begin : g_req
      assign req_a[k] = req_tdata[IDX_W + k*COORD_W +: COORD_W];
      assign req_b[k] = req_tdata[IDX_W + (k+3)*COORD_W +: COORD_W];
      assign cr_hi[k] = cr_ff[k][CROSS_W-1:LO_W];
      assign cr_lo[k] = $signed({1'b0, cr_ff[k][LO_W-1:0]});
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_go     = req_tvalid && req_tready;
   assign req_load   = req_go && (cmd_type'(req_tuser) == CMD_LOAD);
   assign req_test   = req_go && (cmd_type'(req_tuser) == CMD_TEST);
   assign adv        = !rsp_vld_ff || rsp_tready;
   assign issue_go   = (state_ff == ST_RUN) && (issue_ff < n_ff) && adv;

   // final decision on stage 7: before start, past end, or beside the line
   assign hit7   = flg7_ff[0] ? flg7_ff[2] :
                   flg7_ff[1] ? flg7_ff[3] :
                   (nsq_ff <= NSQ_W'(r2c2_ff));
   assign first7 = !marks_ff[idx_ff[7]];

   always_comb begin
      state_in      = state_ff;
      radius_in     = radius_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      issue_in      = issue_ff;
      marks_in      = marks_ff;
      pend_vld_in   = pend_vld_ff;
      pend_idx_in   = pend_idx_ff;
      pend_first_in = pend_first_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_RADIUS: radius_in = csr_wdata[RADIUS_W-1:0];
            CSR_COUNT:  count_in  = csr_wdata[CNT_W-1:0];
            default:    ;
         endcase
      end

      if (req_load) begin
         marks_in[req_idx] = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_test) begin
               n_in        = (count_ff > CNT_W'(MAX_TARGETS)) ? CNT_W'(MAX_TARGETS) : count_ff;
               issue_in    = '0;
               pend_vld_in = 1'b0;
               if ((req_a[0] == req_b[0] && req_a[1] == req_b[1] && req_a[2] == req_b[2])
                   || count_ff == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_RMUL;
         ST_RMUL: state_in = ST_RSUM;
         ST_RSUM: state_in = ST_RUN;
         ST_RUN: begin
            if (issue_go) begin
               issue_in = issue_ff + 1'b1;
            end
            if (issue_ff == n_ff && vld_ff == '0) begin
               state_in = ST_DRAIN;
            end
            if (vld_ff[7] && adv && hit7) begin
               marks_in[idx_ff[7]] = 1'b1;
               if (pend_vld_ff) begin
                  rsp_vld_in   = 1'b1;
                  rsp_hit_in   = 1'b1;
                  rsp_idx_in   = pend_idx_ff;
                  rsp_first_in = pend_first_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_vld_in   = 1'b1;
               pend_idx_in   = idx_ff[7];
               pend_first_in = first7;
            end
         end
         ST_DRAIN: begin
            if (adv) begin
               rsp_vld_in   = 1'b1;
               rsp_hit_in   = pend_vld_ff;
               rsp_idx_in   = pend_vld_ff ? pend_idx_ff : '0;
               rsp_first_in = pend_vld_ff && pend_first_ff;
               rsp_last_in  = 1'b1;
               pend_vld_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         radius_ff   <= '0;
         count_ff    <= '0;
         n_ff        <= '0;
         issue_ff    <= '0;
         marks_ff    <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         vld_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         radius_ff   <= radius_in;
         count_ff    <= count_in;
         n_ff        <= n_in;
         issue_ff    <= issue_in;
         marks_ff    <= marks_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (adv) begin
            vld_ff <= {vld_ff[6:1], issue_go};
         end
      end
      pend_idx_ff   <= pend_idx_in;
      pend_first_ff <= pend_first_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // position memory: loaded in idle, read one target a cycle while running unless stalled
   always_ff @(posedge clock) begin
      if (req_load) begin
         pos_mem[req_idx] <= {req_a[2], req_a[1], req_a[0]};
      end
      if (adv) begin
         rd_ff <= pos_mem[issue_ff[IDX_W-1:0]];
      end
   end

   // segment setup: v, |v|^2, r^2 and r^2 * |v|^2
   always_ff @(posedge clock) begin
      if (req_test) begin
         for (int k = 0; k < 3; k++) begin
            a_ff[k] <= req_a[k];
            b_ff[k] <= req_b[k];
            v_ff[k] <= DIFF_W'(req_b[k]) - DIFF_W'(req_a[k]);
         end
      end
      if (state_ff == ST_SQ) begin
         for (int k = 0; k < 3; k++) begin
            vsq_ff[k] <= v_ff[k] * v_ff[k];
         end
         r2_ff <= radius_ff * radius_ff;
      end
      if (state_ff == ST_SUM) begin
         c2_ff <= SSQ_W'(vsq_ff[0]) + SSQ_W'(vsq_ff[1]) + SSQ_W'(vsq_ff[2]);
      end
      if (state_ff == ST_RMUL) begin
         rlo_ff <= r2_ff * c2_ff[C2LO_W-1:0];
         rhi_ff <= r2_ff * c2_ff[SSQ_W-1:C2LO_W];
      end
      if (state_ff == ST_RSUM) begin
         r2c2_ff <= (R2C2_W'(rhi_ff) << C2LO_W) + R2C2_W'(rlo_ff);
      end
   end

   // target pipeline, moves as a whole when the result side can take a record
   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff[1] <= issue_ff[IDX_W-1:0];
         for (int s = 2; s <= 7; s++) begin
            idx_ff[s] <= idx_ff[s-1];
         end
         // stage 2: offsets from both endpoints
         for (int k = 0; k < 3; k++) begin
            wa_ff[k] <= DIFF_W'($signed(rd_ff[k*COORD_W +: COORD_W])) - DIFF_W'(a_ff[k]);
            wb_ff[k] <= DIFF_W'($signed(rd_ff[k*COORD_W +: COORD_W])) - DIFF_W'(b_ff[k]);
         end
         // stage 3: products
         for (int k = 0; k < 3; k++) begin
            pav_ff[k] <= wa_ff[k] * v_ff[k];
            paa_ff[k] <= wa_ff[k] * wa_ff[k];
            pbb_ff[k] <= wb_ff[k] * wb_ff[k];
         end
         pm_ff[0] <= wa_ff[1] * wb_ff[2];
         pm_ff[1] <= wa_ff[2] * wb_ff[1];
         pm_ff[2] <= wa_ff[2] * wb_ff[0];
         pm_ff[3] <= wa_ff[0] * wb_ff[2];
         pm_ff[4] <= wa_ff[0] * wb_ff[1];
         pm_ff[5] <= wa_ff[1] * wb_ff[0];
         // stage 4: dot products and cross product
         c1_ff <= DOT_W'(pav_ff[0]) + DOT_W'(pav_ff[1]) + DOT_W'(pav_ff[2]);
         da_ff <= SSQ_W'(paa_ff[0]) + SSQ_W'(paa_ff[1]) + SSQ_W'(paa_ff[2]);
         db_ff <= SSQ_W'(pbb_ff[0]) + SSQ_W'(pbb_ff[1]) + SSQ_W'(pbb_ff[2]);
         for (int k = 0; k < 3; k++) begin
            cr_ff[k] <= CROSS_W'(pm_ff[2*k]) - CROSS_W'(pm_ff[2*k+1]);
         end
         // stage 5: region tests and split squares of the cross product
         flg5_ff[0] <= (c1_ff <= DOT_W'(0));
         flg5_ff[1] <= ($signed({1'b0, c2_ff}) <= c1_ff);
         flg5_ff[2] <= (da_ff <= SSQ_W'(r2_ff));
         flg5_ff[3] <= (db_ff <= SSQ_W'(r2_ff));
         for (int k = 0; k < 3; k++) begin
            phh_ff[k] <= PP_W'(cr_hi[k] * cr_hi[k]);
            phl_ff[k] <= PP_W'(cr_hi[k] * cr_lo[k]);
            pll_ff[k] <= cr_ff[k][LO_W-1:0] * cr_ff[k][LO_W-1:0];
         end
         // stage 6: c^2 = hh*2^(2L) + hl*2^(L+1) + ll
         flg6_ff <= flg5_ff;
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= (NSQ_W'(phh_ff[k]) << (2*LO_W)) + (NSQ_W'(phl_ff[k]) << (LO_W+1))
                        + NSQ_W'(pll_ff[k]);
         end
         // stage 7: squared cross product norm
         flg7_ff <= flg6_ff;
         nsq_ff  <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_first_ff, rsp_idx_ff});

   `ASSERT_CLK(a_pipe_run, vld_ff != '0 |-> state_ff == ST_RUN,
      "target pipeline busy outside a segment test")
   `ASSERT_CLK(a_pend_run, pend_vld_ff |-> state_ff == ST_RUN || state_ff == ST_DRAIN,
      "pending hit outside a segment test")
   `ASSERT_CLK(a_nohit_last, rsp_vld_ff && !rsp_hit_ff |-> rsp_last_ff,
      "no-hit result not marked last")
   `ASSERT_CLK(a_mark_set, vld_ff[7] && adv && hit7 |=> marks_ff[$past(idx_ff[7])],
      "detected target not marked found")

endmodule
